>>> design/gha_pkg.sv
package gha_pkg;

  localparam int DEF_SLOTS    = 1024;
  localparam int DEF_GEN_BITS = 16;

  localparam int CMD_W    = 2;
  localparam int STATUS_W = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CREATE   = 2'd0,
    CMD_DESTROY  = 2'd1,
    CMD_VALIDATE = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_POP  = 4'b0010,
    S_TBL  = 4'b0100,
    S_RSVD = 4'b1000
  } state_t;

  typedef enum logic [2:0] {
    ACT_NEW,
    ACT_DESTROY,
    ACT_VALIDATE,
    ACT_FULL,
    ACT_BAD
  } act_t;

endpackage

>>> design/gha_table.sv
module gha_table import gha_pkg::*; #(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int GEN_BITS = DEF_GEN_BITS,
  localparam int IDX_W   = $clog2(SLOTS)
) (
  input  logic                clk,
  input  logic                re,
  input  logic [IDX_W-1:0]    raddr,
  output logic                rd_alive,
  output logic [GEN_BITS-1:0] rd_gen,
  input  logic                we,
  input  logic [IDX_W-1:0]    waddr,
  input  logic                wr_alive,
  input  logic [GEN_BITS-1:0] wr_gen
);

  logic [GEN_BITS:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= {wr_alive, wr_gen};
    end
    if (re) begin
      {rd_alive, rd_gen} <= mem[raddr];
    end
  end

endmodule

>>> design/gha_stack.sv
module gha_stack import gha_pkg::*; #(
  parameter int SLOTS  = DEF_SLOTS,
  localparam int IDX_W = $clog2(SLOTS)
) (
  input  logic             clk,
  input  logic             re,
  input  logic [IDX_W-1:0] raddr,
  output logic [IDX_W-1:0] rdata,
  input  logic             we,
  input  logic [IDX_W-1:0] waddr,
  input  logic [IDX_W-1:0] wdata
);

  logic [IDX_W-1:0] mem [SLOTS];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/generational_handle_allocator_top.sv
// Sequence: a request's result is registered in the table state. A create that pops
// the free stack passes a pop state first (stack read, then table read, then update).
// A new request is taken only once the last one is finished, as set by the serial
// read-modify-write of the slot table through its single registered read port.
// Reset: synchronous, active high; clears counters, control and the output valid flag.
// Table entries at or above the high-water mark are treated as never used.
module generational_handle_allocator_top import gha_pkg::*; #(
  parameter int SLOTS    = DEF_SLOTS,
  parameter int GEN_BITS = DEF_GEN_BITS,
  localparam int IDX_W   = $clog2(SLOTS),
  localparam int CNT_W   = $clog2(SLOTS + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [CMD_W-1:0]    cmd,
  input  logic [IDX_W-1:0]    handle_index,
  input  logic [GEN_BITS-1:0] handle_generation,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [IDX_W-1:0]    result_index,
  output logic [GEN_BITS-1:0] result_generation,
  output logic [CNT_W-1:0]    live_total
);

  state_t state;
  act_t   act;
  logic   fresh;

  logic [IDX_W-1:0]    slot;
  logic [GEN_BITS-1:0] req_gen;
  logic [CNT_W-1:0]    free_top;
  logic [CNT_W-1:0]    high_water;
  logic [CNT_W-1:0]    live_count;

  logic                tbl_re;
  logic [IDX_W-1:0]    tbl_raddr;
  logic                rd_alive;
  logic [GEN_BITS-1:0] rd_gen;
  logic                tbl_we;
  logic                wr_alive;
  logic [GEN_BITS-1:0] wr_gen;

  logic                stk_re;
  logic [IDX_W-1:0]    stk_rdata;
  logic                stk_we;

  logic                accept;
  logic                finish;
  logic                current;
  logic [GEN_BITS-1:0] slot_gen;
  logic [CNT_W-1:0]    live_next;
  logic [STATUS_W-1:0] status_next;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign finish   = (state == S_TBL) && (!out_valid || out_ready);

  assign slot_gen = fresh ? '0 : rd_gen;
  assign current  = rd_alive && (rd_gen == req_gen);

  always_comb begin
    tbl_re    = 1'b0;
    tbl_raddr = handle_index;
    stk_re    = 1'b0;
    if (accept) begin
      if (cmd_t'(cmd) == CMD_CREATE) begin
        stk_re = (free_top != '0);
      end else if (cmd_t'(cmd) == CMD_DESTROY || cmd_t'(cmd) == CMD_VALIDATE) begin
        tbl_re = 1'b1;
      end
    end else if (state == S_POP) begin
      tbl_re    = 1'b1;
      tbl_raddr = stk_rdata;
    end
  end

  always_comb begin
    tbl_we      = 1'b0;
    stk_we      = 1'b0;
    wr_alive    = 1'b0;
    wr_gen      = rd_gen + 1'b1;
    live_next   = live_count;
    status_next = ST_INVALID;
    if (finish) begin
      case (act)
        ACT_NEW: begin
          tbl_we      = 1'b1;
          wr_alive    = 1'b1;
          wr_gen      = slot_gen;
          live_next   = live_count + 1'b1;
          status_next = ST_OK;
        end
        ACT_DESTROY: begin
          if (current) begin
            tbl_we      = 1'b1;
            stk_we      = 1'b1;
            live_next   = live_count - 1'b1;
            status_next = ST_OK;
          end
        end
        ACT_VALIDATE: status_next = current ? ST_OK : ST_INVALID;
        ACT_FULL:     status_next = ST_FULL;
        default:      status_next = ST_INVALID;
      endcase
    end
  end

  gha_table #(.SLOTS(SLOTS), .GEN_BITS(GEN_BITS)) u_table (
    .clk      (clk),
    .re       (tbl_re),
    .raddr    (tbl_raddr),
    .rd_alive (rd_alive),
    .rd_gen   (rd_gen),
    .we       (tbl_we),
    .waddr    (slot),
    .wr_alive (wr_alive),
    .wr_gen   (wr_gen)
  );

  gha_stack #(.SLOTS(SLOTS)) u_stack (
    .clk   (clk),
    .re    (stk_re),
    .raddr (free_top[IDX_W-1:0] - 1'b1),
    .rdata (stk_rdata),
    .we    (stk_we),
    .waddr (free_top[IDX_W-1:0]),
    .wdata (slot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      free_top   <= '0;
      high_water <= '0;
      live_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      if (finish) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            slot    <= handle_index;
            req_gen <= handle_generation;
            fresh   <= 1'b0;
            state   <= S_TBL;
            unique case (cmd_t'(cmd))
              CMD_CREATE: begin
                if (free_top != '0) begin
                  free_top <= free_top - 1'b1;
                  act      <= ACT_NEW;
                  state    <= S_POP;
                end else if (high_water != CNT_W'(SLOTS)) begin
                  slot       <= high_water[IDX_W-1:0];
                  high_water <= high_water + 1'b1;
                  fresh      <= 1'b1;
                  act        <= ACT_NEW;
                end else begin
                  act <= ACT_FULL;
                end
              end
              CMD_DESTROY, CMD_VALIDATE: begin
                if (CNT_W'(handle_index) < high_water) begin
                  act <= (cmd_t'(cmd) == CMD_DESTROY) ? ACT_DESTROY : ACT_VALIDATE;
                end else begin
                  act <= ACT_BAD;
                end
              end
              default: act <= ACT_BAD;
            endcase
          end
        end
        S_POP: begin
          slot  <= stk_rdata;
          state <= S_TBL;
        end
        S_TBL: begin
          if (finish) begin
            if (stk_we) begin
              free_top <= free_top + 1'b1;
            end
            live_count        <= live_next;
            status            <= status_next;
            result_index      <= slot;
            result_generation <= (act == ACT_NEW) ? slot_gen : req_gen;
            live_total        <= live_next;
            state             <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> verif/testbench.sv
module testbench;
  import gha_pkg::*;

  localparam int SLOTS = DEF_SLOTS;
  localparam int GEN_W = DEF_GEN_BITS;
  localparam int IDX_W = $clog2(SLOTS);
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int MAX_PRINTED = 40;
  localparam int REUSE_ROUNDS = 40;

  typedef struct {
    status_t          st;
    logic [IDX_W-1:0] idx;
    logic [GEN_W-1:0] gen;
    logic [CNT_W-1:0] live;
  } handle_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [CMD_W-1:0] cmd = CMD_NONE;
  logic [IDX_W-1:0] handle_index = '0;
  logic [GEN_W-1:0] handle_generation = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [STATUS_W-1:0] status;
  logic [IDX_W-1:0] result_index;
  logic [GEN_W-1:0] result_generation;
  logic [CNT_W-1:0] live_total;

  generational_handle_allocator_top i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .cmd               (cmd),
    .handle_index      (handle_index),
    .handle_generation (handle_generation),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .status            (status),
    .result_index      (result_index),
    .result_generation (result_generation),
    .live_total        (live_total)
  );

  always #5 clk = ~clk;

  // allocator shadow state
  bit               slot_alive [SLOTS];
  logic [GEN_W-1:0] slot_gen [SLOTS];
  logic [IDX_W-1:0] free_slots [$];
  int               live_slots [$];
  int               high_water = 0;
  int               last_new_slot = 0;
  int               reuse_slot = 0;

  handle_result_t   pending_results [$];

  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int num_mismatches = 0;
  int num_checked = 0;
  int num_ok = 0;
  int num_invalid = 0;
  int num_full = 0;

  task automatic report_mismatch(string msg);
    num_mismatches++;
    if (num_mismatches <= MAX_PRINTED)
      $display("mismatch at %0t: %s", $time, msg);
  endtask

  function automatic bit handle_current(logic [IDX_W-1:0] idx, logic [GEN_W-1:0] g);
    return (int'(idx) < high_water) && slot_alive[idx] && (slot_gen[idx] == g);
  endfunction

  function automatic void predict_handle_cmd(cmd_t c, logic [IDX_W-1:0] idx,
                                             logic [GEN_W-1:0] g);
    handle_result_t r;
    int slot;
    r.st  = ST_INVALID;
    r.idx = idx;
    r.gen = g;
    case (c)
      CMD_CREATE: begin
        slot = -1;
        if (free_slots.size() > 0) begin
          slot = int'(free_slots[free_slots.size() - 1]);
          free_slots.delete(free_slots.size() - 1);
        end else if (high_water < SLOTS) begin
          slot = high_water;
          high_water++;
        end
        if (slot >= 0) begin
          slot_alive[slot] = 1'b1;
          live_slots.insert(live_slots.size(), slot);
          last_new_slot = slot;
          r.st  = ST_OK;
          r.idx = IDX_W'(slot);
          r.gen = slot_gen[slot];
        end else begin
          r.st = ST_FULL;
        end
      end
      CMD_DESTROY: begin
        if (handle_current(idx, g)) begin
          slot_alive[idx] = 1'b0;
          slot_gen[idx]   = slot_gen[idx] + 1'b1;
          free_slots.insert(free_slots.size(), idx);
          for (int k = 0; k < live_slots.size(); k++) begin
            if (live_slots[k] == int'(idx)) begin
              live_slots.delete(k);
              break;
            end
          end
          r.st = ST_OK;
        end
      end
      CMD_VALIDATE: begin
        if (handle_current(idx, g)) r.st = ST_OK;
      end
      default: ;
    endcase
    r.live = CNT_W'(live_slots.size());
    pending_results.insert(pending_results.size(), r);
  endfunction

  task automatic send_request(cmd_t c, int idx, int g);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid          <= 1'b1;
    cmd               <= c;
    handle_index      <= IDX_W'(idx);
    handle_generation <= GEN_W'(g);
    predict_handle_cmd(c, IDX_W'(idx), GEN_W'(g));
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic wait_all_results();
    in_valid <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  always @(posedge clk) begin : check_results
    handle_result_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status %0d index %0d",
                                  status, result_index));
      end else begin
        want = pending_results.pop_front();
        num_checked++;
        case (want.st)
          ST_OK:      num_ok++;
          ST_FULL:    num_full++;
          default:    num_invalid++;
        endcase
        if (status !== want.st)
          report_mismatch($sformatf("status %0d, want %0d", status, want.st));
        if (result_index !== want.idx)
          report_mismatch($sformatf("result_index %0d, want %0d", result_index, want.idx));
        if (result_generation !== want.gen)
          report_mismatch($sformatf("result_generation %0h, want %0h",
                                    result_generation, want.gen));
        if (live_total !== want.live)
          report_mismatch($sformatf("live_total %0d, want %0d", live_total, want.live));
      end
    end
  end

  task automatic test_directed();
    send_request(CMD_VALIDATE, 0, 0);
    send_request(CMD_DESTROY, 0, 0);
    send_request(CMD_NONE, SLOTS - 1, '1);
    send_request(CMD_VALIDATE, SLOTS - 1, '1);
    send_request(CMD_CREATE, SLOTS - 1, '1);
    send_request(CMD_CREATE, 0, 0);
    send_request(CMD_VALIDATE, 0, 0);
    send_request(CMD_VALIDATE, 0, 16'h8000);
    send_request(CMD_VALIDATE, 1, 0);
    send_request(CMD_VALIDATE, 2, 0);
    send_request(CMD_DESTROY, 2, 0);
    send_request(CMD_DESTROY, 0, 1);
    send_request(CMD_DESTROY, 0, 0);
    send_request(CMD_DESTROY, 0, 0);
    send_request(CMD_VALIDATE, 0, 1);
    send_request(CMD_DESTROY, 1, 0);
    send_request(CMD_CREATE, 10'h2aa, 16'h5555);
    send_request(CMD_CREATE, 10'h155, 16'haaaa);
    send_request(CMD_CREATE, 0, 0);
    send_request(CMD_NONE, 0, 0);
    send_request(CMD_VALIDATE, 1, 1);
    send_request(CMD_DESTROY, 1, '1);
    send_request(CMD_VALIDATE, 2, 0);
  endtask

  task automatic test_pool_full();
    int k;
    while (live_slots.size() < SLOTS)
      send_request(CMD_CREATE, $urandom_range(SLOTS - 1), $urandom_range(65535));
    send_request(CMD_CREATE, 0, 0);
    send_request(CMD_CREATE, SLOTS - 1, '1);
    send_request(CMD_VALIDATE, SLOTS - 1, slot_gen[SLOTS-1]);
    send_request(CMD_DESTROY, SLOTS - 1, slot_gen[SLOTS-1]);
    send_request(CMD_VALIDATE, SLOTS - 1, slot_gen[SLOTS-1]);
    send_request(CMD_CREATE, 0, 0);
    send_request(CMD_CREATE, 0, 0);
    repeat (SLOTS / 2) begin
      k = $urandom_range(live_slots.size() - 1);
      send_request(CMD_DESTROY, live_slots[k], slot_gen[live_slots[k]]);
    end
  endtask

  task automatic test_random(int n);
    int r, cw, k, idx;
    logic [GEN_W-1:0] g;
    repeat (n) begin
      if ($urandom_range(199) == 0) wait_all_results();
      r  = $urandom_range(99);
      cw = (live_slots.size() < SLOTS / 2) ? 45 : 30;
      if (live_slots.size() == 0 || r < cw) begin
        send_request(CMD_CREATE, $urandom_range(SLOTS - 1), $urandom_range(65535));
      end else if (r < cw + 28) begin
        k = $urandom_range(live_slots.size() - 1);
        send_request(CMD_DESTROY, live_slots[k], slot_gen[live_slots[k]]);
      end else if (r < cw + 40) begin
        k = $urandom_range(live_slots.size() - 1);
        send_request(CMD_VALIDATE, live_slots[k], slot_gen[live_slots[k]]);
      end else if (r < cw + 52) begin
        // any used slot, live or dead, with its generation or one bit flipped
        idx = $urandom_range(high_water - 1);
        g = slot_gen[idx];
        if ($urandom_range(1)) g = g ^ (16'h1 << $urandom_range(GEN_W - 1));
        send_request($urandom_range(1) ? CMD_DESTROY : CMD_VALIDATE, idx, g);
      end else begin
        send_request(cmd_t'($urandom_range(3)), $urandom_range(SLOTS - 1),
                     $urandom_range(65535));
      end
    end
  endtask

  task automatic test_slot_reuse();
    if (live_slots.size() == SLOTS)
      send_request(CMD_DESTROY, live_slots[0], slot_gen[live_slots[0]]);
    send_request(CMD_CREATE, 0, 0);
    reuse_slot = last_new_slot;
    repeat (REUSE_ROUNDS) begin
      send_request(CMD_DESTROY, reuse_slot, slot_gen[reuse_slot]);
      send_request(CMD_CREATE, 0, 0);
    end
    send_request(CMD_VALIDATE, reuse_slot, slot_gen[reuse_slot]);
  endtask

  initial begin
    slot_gen = '{default: '0};
    slot_alive = '{default: 1'b0};
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    tx_idle_pct = 38;
    rx_idle_pct = 45;
    test_directed();
    wait_all_results();
    test_pool_full();
    test_random(150);
    wait_all_results();

    tx_idle_pct = 45;
    rx_idle_pct = 38;
    test_random(150);
    wait_all_results();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random(100);
    test_slot_reuse();

    wait_all_results();
    repeat (10) @(posedge clk);
    $display("checked %0d results: %0d ok, %0d invalid or stale, %0d full",
             num_checked, num_ok, num_invalid, num_full);
    $display("pool filled to %0d slots; slot %0d freed and retaken %0d times",
             SLOTS, reuse_slot, REUSE_ROUNDS);
    if (num_mismatches == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

  initial begin
    #30_000_000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("testbench NOT OK");
    $finish;
  end

endmodule
